/* hdl/ccd_pkg.sv */
package ccd_pkg;

	localparam int SLOTS_DEF = 8;
	localparam int QDEPTH = 2;
	localparam logic [15:0] STOCK_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CHANGE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_DONE    = 3'd0,
		ST_SHORT   = 3'd1,
		ST_UNKNOWN = 3'd2,
		ST_FULL    = 3'd3,
		ST_SAT     = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] coin_value;
		logic [15:0] coin_count;
		logic [23:0] change_due;
	} item_t;

	typedef struct packed {
		logic [15:0] paid_value;
		logic [15:0] paid_count;
		logic        ok;
		logic [2:0]  status;
		logic        last;
	} result_t;

endpackage

/* hdl/ccd_if.sv */
interface ccd_item_if;
	logic             valid;
	logic             ready;
	ccd_pkg::item_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ccd_result_if;
	logic             valid;
	logic             ready;
	ccd_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/coin_change_dispenser_core.sv */
// channel  | role   | payload
// item_in  | sink   | op, coin_value, coin_count, change_due
// res_out  | source | paid_value, paid_count, ok, status, last
// A change plan runs the 24-step restoring divider once per denomination used,
// scanning the slots from the largest coin value down.
// Reset clears the coin table at once; no clearing pass.
// A two-entry queue lets the front accept while the back end is busy or stalled.
module coin_change_dispenser_core #(
	parameter int SLOTS = ccd_pkg::SLOTS_DEF
) (
	input logic   clk,
	input logic   arst_n,
	ccd_item_if.sink     item_in,
	ccd_result_if.source res_out
);
	logic q_valid, q_ready;
	ccd_pkg::item_t q_data;

	ccd_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(item_in.valid), .in_ready(item_in.ready), .in_data(item_in.data),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	ccd_back #(.SLOTS(SLOTS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
		.out_valid(res_out.valid), .out_ready(res_out.ready), .out_data(res_out.data)
	);
endmodule

/* hdl/ccd_front.sv */
// Accept beats, drop no-op codes, and queue the rest for the back end.
module ccd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ccd_pkg::item_t in_data,
	output logic           q_valid,
	input  logic           q_ready,
	output ccd_pkg::item_t q_data
);
	localparam int AW = $clog2(ccd_pkg::QDEPTH);

	ccd_pkg::item_t mem_q [ccd_pkg::QDEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != AW'(0) + (AW+1)'(ccd_pkg::QDEPTH));
	assign push = in_valid && in_ready && (in_data.op != ccd_pkg::OP_NONE);
	assign q_valid = (cnt_q != '0);
	assign pop = q_valid && q_ready;
	assign q_data = mem_q[rp_q];

	// Store queued items
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(ccd_pkg::QDEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (rp_q == AW'(ccd_pkg::QDEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

/* hdl/ccd_div.sv */
// Restoring divider: 24-bit dividend by 16-bit divisor, one quotient bit a cycle.
module ccd_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [23:0] dividend,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic [23:0] quot
);
	logic [4:0]  step_q;
	logic        busy_q;
	logic [23:0] quo_q;
	logic [16:0] rem_q;
	logic [15:0] dsr_q;
	logic [16:0] trial;

	assign trial = {rem_q[15:0], quo_q[23]};
	assign busy = busy_q;
	assign quot = quo_q;

	// Shift one dividend bit in and subtract when it fits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= 5'd0;
		end else if (busy_q) begin
			step_q <= step_q + 5'd1;
			if (step_q == 5'd23) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= trial - {1'b0, dsr_q};
				quo_q <= {quo_q[22:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[22:0], 1'b0};
			end
		end
	end
endmodule

/* hdl/ccd_back.sv */
// Keep the coin table and execute add, remove and change plans.
module ccd_back #(
	parameter int SLOTS = ccd_pkg::SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_ready,
	input  ccd_pkg::item_t   q_data,
	output logic             out_valid,
	input  logic             out_ready,
	output ccd_pkg::result_t out_data
);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SCAN  = 7'b0000010,
		S_DIVGO = 7'b0000100,
		S_DIVW  = 7'b0001000,
		S_TAKE  = 7'b0010000,
		S_EMIT  = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q;
	logic [15:0] val_q [SLOTS];
	logic [15:0] stk_q [SLOTS];
	logic [CW-1:0] used_q;
	ccd_pkg::item_t it_q;
	logic [CW-1:0] idx_q;      // slots left to scan
	logic [23:0] rest_q;
	logic [15:0] pv_q [SLOTS];
	logic [15:0] pc_q [SLOTS];
	logic [CW-1:0] n_q, k_q;
	ccd_pkg::result_t res_q;
	logic ovalid_q;

	logic div_start, div_busy;
	logic [23:0] div_quot;
	logic [IW-1:0] cur;
	logic [15:0] coin, have, take;
	logic [39:0] prod;

	// Lookup of the queued coin value and of its sorted insertion position
	logic hit;
	logic [IW-1:0] hidx;
	logic [CW-1:0] ipos;
	always_comb begin
		hit = 1'b0;
		hidx = '0;
		ipos = used_q;
		for (int i = 0; i < SLOTS; i++) begin
			if (CW'(i) < used_q && val_q[i] == q_data.coin_value && !hit) begin
				hit = 1'b1;
				hidx = IW'(i);
			end
		end
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (CW'(i) < used_q && val_q[i] > q_data.coin_value) ipos = CW'(i);
		end
	end

	assign cur = IW'(idx_q - CW'(1));
	assign coin = val_q[cur];
	assign have = stk_q[cur];
	assign take = (div_quot > {8'd0, have}) ? have : div_quot[15:0];
	assign prod = coin * take;
	assign div_start = (state_q == S_DIVGO);

	ccd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(rest_q), .divisor(coin), .busy(div_busy), .quot(div_quot)
	);

	assign q_ready = (state_q == S_IDLE) && !ovalid_q;
	assign out_valid = ovalid_q;
	assign out_data = res_q;

	logic [16:0] sum;
	assign sum = {1'b0, stk_q[hidx]} + {1'b0, q_data.coin_count};

	// Classify the queued beat into its first result
	logic idle_ok;
	ccd_pkg::status_t idle_st;
	always_comb begin
		idle_ok = 1'b0;
		idle_st = ccd_pkg::ST_DONE;
		if (q_data.op == ccd_pkg::OP_CHANGE) begin
			idle_ok = (q_data.change_due == '0);
		end else if (q_data.coin_value == '0) begin
			idle_st = ccd_pkg::ST_UNKNOWN;
		end else if (q_data.op == ccd_pkg::OP_ADD) begin
			if (hit) begin
				idle_ok = 1'b1;
				if (sum[16]) idle_st = ccd_pkg::ST_SAT;
			end else if (used_q == CW'(SLOTS)) begin
				idle_st = ccd_pkg::ST_FULL;
			end else begin
				idle_ok = 1'b1;
			end
		end else begin
			if (!hit) idle_st = ccd_pkg::ST_UNKNOWN;
			else if (stk_q[hidx] < q_data.coin_count) idle_st = ccd_pkg::ST_SHORT;
			else idle_ok = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			ovalid_q <= 1'b0;
			idx_q <= '0;
			n_q <= '0;
			k_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				val_q[i] <= '0;
				stk_q[i] <= '0;
			end
		end else begin
			if (ovalid_q && out_ready && state_q != S_EMIT) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid && !ovalid_q) begin
						it_q <= q_data;
						res_q <= '{paid_value: '0, paid_count: '0, ok: idle_ok,
							status: idle_st, last: 1'b1};
						if (q_data.op == ccd_pkg::OP_CHANGE) begin
							rest_q <= q_data.change_due;
							idx_q <= used_q;
							n_q <= '0;
							if (q_data.change_due == '0) begin
								ovalid_q <= 1'b1;
							end else begin
								state_q <= S_SCAN;
							end
						end else begin
							ovalid_q <= 1'b1;
							if (q_data.coin_value != '0) begin
								if (q_data.op == ccd_pkg::OP_ADD) begin
									if (hit) begin
										if (sum[16]) stk_q[hidx] <= ccd_pkg::STOCK_MAX;
										else stk_q[hidx] <= sum[15:0];
									end else if (used_q != CW'(SLOTS)) begin
										used_q <= used_q + CW'(1);
										for (int i = 0; i < SLOTS; i++) begin
											if (CW'(i) == ipos) begin
												val_q[i] <= q_data.coin_value;
												stk_q[i] <= q_data.coin_count;
											end else if (CW'(i) > ipos && CW'(i) <= used_q) begin
												val_q[i] <= val_q[i-1];
												stk_q[i] <= stk_q[i-1];
											end
										end
									end
								end else if (hit && stk_q[hidx] >= q_data.coin_count) begin
									stk_q[hidx] <= stk_q[hidx] - q_data.coin_count;
								end
							end
						end
					end
				end
				S_SCAN: begin
					if (idx_q == '0) begin
						if (rest_q != '0 || n_q == '0) begin
							res_q.status <= ccd_pkg::ST_SHORT;
							ovalid_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							k_q <= '0;
							state_q <= S_EMIT;
						end
					end else if (coin == '0 || {8'd0, coin} > rest_q || have == '0) begin
						idx_q <= idx_q - CW'(1);
					end else begin
						state_q <= S_DIVGO;
					end
				end
				S_DIVGO: state_q <= S_DIVW;
				S_DIVW: if (!div_busy) state_q <= S_TAKE;
				S_TAKE: begin
					rest_q <= rest_q - prod[23:0];
					pv_q[n_q[IW-1:0]] <= coin;
					pc_q[n_q[IW-1:0]] <= take;
					n_q <= n_q + CW'(1);
					idx_q <= idx_q - CW'(1);
					state_q <= S_SCAN;
				end
				S_EMIT: begin
					if (!ovalid_q || out_ready) begin
						res_q <= '{paid_value: pv_q[k_q[IW-1:0]],
							paid_count: pc_q[k_q[IW-1:0]], ok: 1'b1,
							status: ccd_pkg::ST_DONE, last: (k_q == n_q - CW'(1))};
						ovalid_q <= 1'b1;
						k_q <= k_q + CW'(1);
						if (k_q == n_q - CW'(1)) state_q <= S_OUT;
					end
				end
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic unused;
	assign unused = ^it_q;
endmodule

/* hdl/ccd_checker.sv */
module ccd_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input ccd_pkg::result_t out_data
);
	// Hold a stalled beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	// Failed results are single and empty
	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.ok |-> out_data.last && out_data.paid_value == '0)
		else $error("fail result malformed");
	// Non-final results carry a coin
	a_plan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> out_data.paid_value != '0 && out_data.ok)
		else $error("plan beat malformed");
	// Status within range
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= ccd_pkg::ST_SAT)
		else $error("bad status");
endmodule

bind coin_change_dispenser_core ccd_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(res_out.valid),
	.out_ready(res_out.ready), .out_data(res_out.data)
);

/* test/coin_change_dispenser_checker.sv */
module coin_change_dispenser_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input ccd_pkg::item_t item_data,
	input logic res_valid,
	input logic res_ready,
	input ccd_pkg::result_t res_data,
	output int fail_count,
	output int pending_count
);
	logic [15:0] coin_tab[8];
	logic [15:0] stock_tab[8];
	int unsigned used_slots;
	ccd_pkg::result_t plan_q[$];

	assign pending_count = plan_q.size();

	function automatic ccd_pkg::result_t make_res(logic [15:0] pv, logic [15:0] pc, logic ok,
			ccd_pkg::status_t st, logic lst);
		ccd_pkg::result_t r;
		r.paid_value = pv;
		r.paid_count = pc;
		r.ok = ok;
		r.status = st;
		r.last = lst;
		return r;
	endfunction

	// update the coin table and queue the results one beat causes
	task automatic apply_item(ccd_pkg::item_t it);
		int s;
		int pos;
		logic [16:0] sum;
		logic [23:0] rest;
		logic [23:0] x;
		logic [15:0] pv[8];
		logic [15:0] pc[8];
		int n;
		s = -1;
		n = 0;
		for (int i = 0; i < used_slots; i++)
			if (coin_tab[i] == it.coin_value && s < 0) s = i;
		case (ccd_pkg::op_t'(it.op))
			ccd_pkg::OP_ADD: begin
				if (it.coin_value == 0) begin
					plan_q.push_back(make_res(0, 0, 0, ccd_pkg::ST_UNKNOWN, 1));
				end else if (s >= 0) begin
					sum = stock_tab[s] + it.coin_count;
					if (sum > ccd_pkg::STOCK_MAX) begin
						stock_tab[s] = ccd_pkg::STOCK_MAX;
						plan_q.push_back(make_res(0, 0, 1, ccd_pkg::ST_SAT, 1));
					end else begin
						stock_tab[s] = sum[15:0];
						plan_q.push_back(make_res(0, 0, 1, ccd_pkg::ST_DONE, 1));
					end
				end else if (used_slots >= 8) begin
					plan_q.push_back(make_res(0, 0, 0, ccd_pkg::ST_FULL, 1));
				end else begin
					pos = used_slots;
					while (pos > 0 && coin_tab[pos-1] > it.coin_value) begin
						coin_tab[pos] = coin_tab[pos-1];
						stock_tab[pos] = stock_tab[pos-1];
						pos--;
					end
					coin_tab[pos] = it.coin_value;
					stock_tab[pos] = it.coin_count;
					used_slots++;
					plan_q.push_back(make_res(0, 0, 1, ccd_pkg::ST_DONE, 1));
				end
			end
			ccd_pkg::OP_REMOVE: begin
				if (it.coin_value == 0 || s < 0) begin
					plan_q.push_back(make_res(0, 0, 0, ccd_pkg::ST_UNKNOWN, 1));
				end else if (stock_tab[s] < it.coin_count) begin
					plan_q.push_back(make_res(0, 0, 0, ccd_pkg::ST_SHORT, 1));
				end else begin
					stock_tab[s] = stock_tab[s] - it.coin_count;
					plan_q.push_back(make_res(0, 0, 1, ccd_pkg::ST_DONE, 1));
				end
			end
			ccd_pkg::OP_CHANGE: begin
				rest = it.change_due;
				if (rest == 0) begin
					plan_q.push_back(make_res(0, 0, 1, ccd_pkg::ST_DONE, 1));
				end else begin
					// walk from the largest coin down
					for (int i = used_slots - 1; i >= 0; i--) begin
						if (coin_tab[i] != 0 && coin_tab[i] <= rest) begin
							x = rest / coin_tab[i];
							if (x > stock_tab[i]) x = stock_tab[i];
							if (x != 0) begin
								rest = rest - coin_tab[i] * x;
								pv[n] = coin_tab[i];
								pc[n] = x[15:0];
								n++;
							end
						end
					end
					if (rest != 0 || n == 0)
						plan_q.push_back(make_res(0, 0, 0, ccd_pkg::ST_SHORT, 1));
					else
						for (int k = 0; k < n; k++)
							plan_q.push_back(make_res(pv[k], pc[k], 1, ccd_pkg::ST_DONE,
								k == n - 1));
				end
			end
			default: ;
		endcase
	endtask

	// compare each result beat with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		ccd_pkg::result_t want;
		if (!arst_n) begin
			used_slots = 0;
			for (int i = 0; i < 8; i++) begin
				coin_tab[i] = 0;
				stock_tab[i] = 0;
			end
			plan_q.delete();
			fail_count <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (plan_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result beat: %p", res_data);
					fail_count <= fail_count + 1;
				end else begin
					want = plan_q.pop_front();
					if (want !== res_data) begin
						if (fail_count < 10)
							$display("mismatch: expected %p got %p", want, res_data);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (item_valid && item_ready)
				apply_item(item_data);
		end
	end
endmodule

/* test/coin_change_dispenser_core_test.sv */
module coin_change_dispenser_core_test;
	logic clk = 0;
	logic arst_n = 0;
	int fail_count;
	int pending_count;
	int hold_off = 0;
	logic [15:0] coin_set[8] = '{1, 2, 5, 10, 25, 50, 100, 65535};

	ccd_item_if item_in();
	ccd_result_if res_out();

	coin_change_dispenser_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_in(item_in),
		.res_out(res_out)
	);

	coin_change_dispenser_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_in.valid),
		.item_ready(item_in.ready),
		.item_data(item_in.data),
		.res_valid(res_out.valid),
		.res_ready(res_out.ready),
		.res_data(res_out.data),
		.fail_count(fail_count),
		.pending_count(pending_count)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		item_in.valid = 0;
		item_in.data = '0;
		res_out.ready = 0;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 3);
	endfunction

	// send one beat and hold it until taken
	task automatic send_item(ccd_pkg::op_t op, logic [15:0] v, logic [15:0] c,
			logic [23:0] d);
		int g;
		ccd_pkg::item_t it;
		g = gap_len();
		if (g > 0) begin
			item_in.valid <= 0;
			repeat (g) @(posedge clk);
		end
		it.op = op;
		it.coin_value = v;
		it.coin_count = c;
		it.change_due = d;
		item_in.valid <= 1;
		item_in.data <= it;
		@(posedge clk);
		while (!item_in.ready) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_coin();
		if ($urandom_range(0, 4) == 0) return 16'($urandom_range(0, 65535));
		return coin_set[$urandom_range(0, 7)];
	endfunction

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				res_out.ready <= 0;
				hold_off = hold_off - 1;
			end else if (res_out.ready) begin
				if ($urandom_range(0, 3) == 0) res_out.ready <= 0;
			end else begin
				g = gap_len();
				if (g == 0) res_out.ready <= 1;
			end
		end
	end

	initial begin
		#20000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int r;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed part
		send_item(ccd_pkg::OP_CHANGE, 0, 0, 0);
		send_item(ccd_pkg::OP_CHANGE, 0, 0, 24'hFFFFFF);
		send_item(ccd_pkg::OP_REMOVE, 5, 1, 0);
		send_item(ccd_pkg::OP_ADD, 0, 3, 0);
		send_item(ccd_pkg::OP_REMOVE, 0, 3, 0);
		send_item(ccd_pkg::OP_ADD, 25, 0, 0);
		send_item(ccd_pkg::OP_ADD, 10, 4, 0);
		send_item(ccd_pkg::OP_ADD, 1, 65535, 0);
		send_item(ccd_pkg::OP_ADD, 1, 1, 0);
		send_item(ccd_pkg::OP_ADD, 65535, 3, 0);
		send_item(ccd_pkg::OP_ADD, 5, 2, 0);
		send_item(ccd_pkg::OP_ADD, 2, 7, 0);
		send_item(ccd_pkg::OP_ADD, 50, 9, 0);
		send_item(ccd_pkg::OP_ADD, 100, 65535, 0);
		send_item(ccd_pkg::OP_ADD, 7, 1, 0);
		send_item(ccd_pkg::OP_REMOVE, 10, 5, 0);
		send_item(ccd_pkg::OP_REMOVE, 10, 4, 0);
		send_item(ccd_pkg::OP_NONE, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
		send_item(ccd_pkg::OP_CHANGE, 0, 0, 188);
		send_item(ccd_pkg::OP_CHANGE, 0, 0, 24'hFFFFFF);
		send_item(ccd_pkg::OP_CHANGE, 0, 0, 3);
		send_item(ccd_pkg::OP_CHANGE, 0, 0, 24'(65535 * 3 + 100 + 57));
		// long stall while the sender keeps offering
		hold_off = 400;
		for (int i = 0; i < 10; i++)
			send_item(ccd_pkg::OP_CHANGE, 0, 0, 24'($urandom_range(1, 2000)));
		// random part
		for (int i = 0; i < 320; i++) begin
			r = $urandom_range(0, 19);
			if (r < 6)
				send_item(ccd_pkg::OP_ADD, pick_coin(), 16'($urandom_range(0, 1) ?
					$urandom_range(0, 50) : $urandom_range(0, 65535)), 24'($urandom()));
			else if (r < 10)
				send_item(ccd_pkg::OP_REMOVE, pick_coin(), 16'($urandom_range(0, 1) ?
					$urandom_range(0, 20) : $urandom_range(0, 65535)), 24'($urandom()));
			else if (r < 19)
				send_item(ccd_pkg::OP_CHANGE, 16'($urandom()), 16'($urandom()),
					24'($urandom_range(0, 2) == 0 ?
					$urandom_range(0, 24'hFFFFFF) : $urandom_range(0, 3000)));
			else
				send_item(ccd_pkg::OP_NONE, 16'($urandom()), 16'($urandom()),
					24'($urandom()));
		end
		item_in.valid <= 0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

/* files.f */
hdl/ccd_pkg.sv
hdl/ccd_if.sv
hdl/ccd_front.sv
hdl/ccd_div.sv
hdl/ccd_back.sv
hdl/coin_change_dispenser_core.sv
hdl/ccd_checker.sv
test/coin_change_dispenser_checker.sv
test/coin_change_dispenser_core_test.sv
